// File: rtl/core/fnv1a32_bucket_index_macros.svh
// ----------------------------------------------------------------------------
// FNV-1a bucket index assertion macros
// Shared assertion forms for the checker of the FNV-1a bucket index block.
// ----------------------------------------------------------------------------
`ifndef FNV1A32_BUCKET_INDEX_MACROS_SVH
`define FNV1A32_BUCKET_INDEX_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FNV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// A stalled item keeps its payload.
`define FNV_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error(msg);

`endif

// File: rtl/core/fnvbi_pkg.sv
// ----------------------------------------------------------------------------
// FNV-1a bucket index package
// Widths, hash constants and the divider status type.
// ----------------------------------------------------------------------------
package fnvbi_pkg;

  localparam int HASH_W = 32;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

  typedef struct packed {
    logic busy;
  } div_status_t;

endpackage

// File: rtl/core/fnvbi_mix.sv
// ----------------------------------------------------------------------------
// FNV-1a mixing step
// XORs one key byte into the hash and multiplies by the FNV prime mod 2^32.
// ----------------------------------------------------------------------------
module fnvbi_mix (
  input  logic [fnvbi_pkg::HASH_W-1:0] hash_in,
  input  logic [fnvbi_pkg::BYTE_W-1:0] key_byte,
  output logic [fnvbi_pkg::HASH_W-1:0] hash_out
);

  logic [fnvbi_pkg::HASH_W-1:0] mixed;

  assign mixed    = hash_in ^ {{(fnvbi_pkg::HASH_W-fnvbi_pkg::BYTE_W){1'b0}}, key_byte};
  assign hash_out = mixed * fnvbi_pkg::FNV_PRIME;

endmodule

// File: rtl/core/fnvbi_div.sv
// ----------------------------------------------------------------------------
// FNV-1a remainder unit
// Restoring shift-subtract unit that decides one quotient bit per cycle while busy,
// discards the quotient and keeps the remainder of a 32-bit dividend over a nonzero 32-bit divisor.
// ----------------------------------------------------------------------------
module fnvbi_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fnvbi_pkg::HASH_W-1:0]  dividend,
  input  logic [fnvbi_pkg::HASH_W-1:0]  divisor,
  output logic [fnvbi_pkg::HASH_W-1:0]  remainder,
  output fnvbi_pkg::div_status_t        status
);

  logic [fnvbi_pkg::HASH_W-1:0] dvd;
  logic [fnvbi_pkg::HASH_W-1:0] dsr;
  logic [fnvbi_pkg::HASH_W-1:0] rem;
  logic [fnvbi_pkg::HASH_W-1:0] rem_next;
  logic [fnvbi_pkg::CNT_W-1:0]  cnt;
  logic                         busy;
  logic [fnvbi_pkg::HASH_W:0]   trial;

  assign trial = {rem, dvd[fnvbi_pkg::HASH_W-1]};

  always_comb begin
    if (trial >= {1'b0, dsr}) begin
      rem_next = fnvbi_pkg::HASH_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[fnvbi_pkg::HASH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[fnvbi_pkg::HASH_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
      if (cnt == {fnvbi_pkg::CNT_W{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  assign remainder   = rem;
  assign status.busy = busy;

endmodule

// File: rtl/core/fnv1a32_bucket_index.sv
// Middle key bytes fold into the running hash; a new byte is accepted every
// cycle while the block is idle. A final byte or an empty-key item is
// reduced by the 32 one-bit steps of the remainder unit before its result is valid.
// Input is not accepted again until that result is loaded into the output register.
// Synchronous reset loads the offset basis, sets the bucket count to one
// and empties the output register.
// ----------------------------------------------------------------------------
// FNV-1a bucket index
// Streams key bytes through a running FNV-1a hash and gives the finished
// hash with its bucket index modulo the configured bucket count (zero acts as one).
// ----------------------------------------------------------------------------
module fnv1a32_bucket_index (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fnvbi_pkg::HASH_W-1:0]    cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [fnvbi_pkg::BYTE_W-1:0]    s_axis_tdata,   // key_byte
  input  logic                            s_axis_tlast,   // last_byte
  input  logic                            s_axis_tuser,   // empty_key
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [2*fnvbi_pkg::HASH_W-1:0]  m_axis_tdata    // bucket_index, hash_value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV
  } state_t;

  state_t                        state;
  logic [fnvbi_pkg::HASH_W-1:0]  running_hash;
  logic [fnvbi_pkg::HASH_W-1:0]  bucket_count;
  logic [fnvbi_pkg::HASH_W-1:0]  eff_count;
  logic [fnvbi_pkg::HASH_W-1:0]  hash_res;
  logic [fnvbi_pkg::HASH_W-1:0]  product;
  logic [fnvbi_pkg::HASH_W-1:0]  remainder;
  logic [fnvbi_pkg::HASH_W-1:0]  out_hash;
  logic [fnvbi_pkg::HASH_W-1:0]  out_index;
  logic                          out_valid;
  logic                          out_load;
  logic                          in_acc;
  fnvbi_pkg::div_status_t        div_status;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign eff_count     = (bucket_count == '0) ? fnvbi_pkg::HASH_W'(1) : bucket_count;
  assign out_load      = (state == S_DIV) && !div_status.busy && (!out_valid || m_axis_tready);

  fnvbi_mix u_mix (
    .hash_in  (running_hash),
    .key_byte (s_axis_tdata),
    .hash_out (product)
  );

  fnvbi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_START),
    .dividend  (hash_res),
    .divisor   (eff_count),
    .remainder (remainder),
    .status    (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= fnvbi_pkg::FNV_OFFSET;
      bucket_count <= fnvbi_pkg::HASH_W'(1);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser) begin
              hash_res     <= fnvbi_pkg::FNV_OFFSET;
              running_hash <= fnvbi_pkg::FNV_OFFSET;
              state        <= S_START;
            end else if (s_axis_tlast) begin
              hash_res     <= product;
              running_hash <= fnvbi_pkg::FNV_OFFSET;
              state        <= S_START;
            end else begin
              running_hash <= product;
            end
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (out_load) begin
            out_hash  <= hash_res;
            out_index <= remainder;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_index, out_hash};

endmodule

// File: rtl/core/fnvbi_checker.sv
// ----------------------------------------------------------------------------
// FNV-1a bucket index checker
// Port-level assertions on the FNV-1a bucket index block, bound to its top.
// ----------------------------------------------------------------------------
`include "fnv1a32_bucket_index_macros.svh"

module fnvbi_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fnvbi_pkg::HASH_W-1:0]    cfg_wdata,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [2*fnvbi_pkg::HASH_W-1:0]  m_axis_tdata
);

  logic [fnvbi_pkg::HASH_W-1:0] count_mirror;
  logic [fnvbi_pkg::HASH_W-1:0] eff_mirror;
  logic                         key_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mirror <= fnvbi_pkg::HASH_W'(1);
    end else if (cfg_we) begin
      count_mirror <= cfg_wdata;
    end
  end

  assign eff_mirror = (count_mirror == '0) ? fnvbi_pkg::HASH_W'(1) : count_mirror;
  assign key_end    = s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser);

  `FNV_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "Stalled result changed.")
  `FNV_ASSERT_SAME(a_reset_empty, $past(rst), !m_axis_tvalid, "Result valid right after reset.")
  `FNV_ASSERT_NEXT(a_busy_after_key, key_end, !s_axis_tready, "Input ready while finishing a key.")
  `FNV_ASSERT_SAME(a_index_range, m_axis_tvalid,
                   m_axis_tdata[2*fnvbi_pkg::HASH_W-1:fnvbi_pkg::HASH_W] < eff_mirror,
                   "Bucket index not below the bucket count.")

endmodule

bind fnv1a32_bucket_index fnvbi_checker u_fnvbi_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_we        (cfg_we),
  .cfg_wdata     (cfg_wdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
